[design/vdc_pkg.sv]
`default_nettype none

package vdc_pkg;

  // Storage sizes
  localparam int VRAM_WORDS  = 65536;
  localparam int VRAM_AW     = $clog2(VRAM_WORDS);
  localparam int REG_COUNT   = 32;
  localparam int REG_AW      = $clog2(REG_COUNT);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Bus command codes
  localparam logic [2:0] CMD_SELECT = 3'd0;
  localparam logic [2:0] CMD_WR_LO  = 3'd1;
  localparam logic [2:0] CMD_WR_HI  = 3'd2;
  localparam logic [2:0] CMD_RD_LO  = 3'd3;
  localparam logic [2:0] CMD_RD_HI  = 3'd4;
  localparam logic [2:0] CMD_STATUS = 3'd5;
  localparam logic [2:0] CMD_TICK   = 3'd6;

  // Register numbers
  localparam logic [REG_AW-1:0] REG_MAWR = REG_AW'(0);   // write address
  localparam logic [REG_AW-1:0] REG_MARR = REG_AW'(1);   // read address
  localparam logic [REG_AW-1:0] REG_VRR  = REG_AW'(2);   // data port
  localparam logic [REG_AW-1:0] REG_VRRH = REG_AW'(3);   // data port mirror
  localparam logic [REG_AW-1:0] REG_CR   = REG_AW'(5);   // control
  localparam logic [REG_AW-1:0] REG_MWR  = REG_AW'(9);
  localparam logic [REG_AW-1:0] REG_HSR  = REG_AW'(10);
  localparam logic [REG_AW-1:0] REG_HDR  = REG_AW'(11);
  localparam logic [REG_AW-1:0] REG_VPR  = REG_AW'(12);
  localparam logic [REG_AW-1:0] REG_VDW  = REG_AW'(13);
  localparam logic [REG_AW-1:0] REG_VCR  = REG_AW'(14);
  localparam logic [REG_AW-1:0] REG_DCR  = REG_AW'(15);  // copy control
  localparam logic [REG_AW-1:0] REG_SOUR = REG_AW'(16);  // copy source
  localparam logic [REG_AW-1:0] REG_DESR = REG_AW'(17);  // copy destination
  localparam logic [REG_AW-1:0] REG_LENR = REG_AW'(18);  // copy length

  // Status bit positions
  localparam int STAT_DONE = 4;
  localparam int STAT_BUSY = 6;
  localparam logic [6:0] STAT_KEEP_MASK = 7'h40;

  // Work items after decode
  typedef enum logic [3:0] {
    OP_LATCH_LO   = 4'd0,
    OP_REG_LO     = 4'd1,
    OP_VRAM_WR    = 4'd2,
    OP_REG_HI     = 4'd3,
    OP_RD_LO      = 4'd4,
    OP_RD_HI_DATA = 4'd5,
    OP_RD_HI_REG  = 4'd6,
    OP_STATUS     = 4'd7,
    OP_TICK       = 4'd8
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [REG_AW-1:0] sel;
    logic [7:0]        data;
    logic [7:0]        elapsed;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Register file values after reset
  function automatic logic [15:0] reg_reset_value(input logic [REG_AW-1:0] idx);
    logic [15:0] v;
    case (idx)
      REG_MWR: v = 16'h0010;
      REG_HSR: v = 16'h0202;
      REG_HDR: v = 16'h031f;
      REG_VPR: v = 16'h0f02;
      REG_VDW: v = 16'h00ef;
      REG_VCR: v = 16'h0003;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[design/vdc_front.sv]
`default_nettype none

module vdc_front
  import vdc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] data_byte,
  input  logic [7:0] elapsed_clocks,
  input  qstat_t qstat,
  output logic   push,
  output item_t  push_item
);

  logic              accept;
  logic              keep;
  logic [REG_AW-1:0] register_select;

  assign req_stall = qstat.full;
  assign accept    = req_valid && !qstat.full;

  // Decode the access against the current register select
  always_comb begin
    push_item.sel     = register_select;
    push_item.data    = data_byte;
    push_item.elapsed = elapsed_clocks;
    push_item.op      = OP_TICK;
    keep              = 1'b1;
    case (cmd)
      CMD_WR_LO: begin
        push_item.op = (register_select == REG_VRR) ? OP_LATCH_LO : OP_REG_LO;
      end
      CMD_WR_HI: begin
        push_item.op = (register_select == REG_VRR) ? OP_VRAM_WR : OP_REG_HI;
      end
      CMD_RD_LO: begin
        push_item.op = OP_RD_LO;
      end
      CMD_RD_HI: begin
        push_item.op = (register_select == REG_VRR || register_select == REG_VRRH) ?
                       OP_RD_HI_DATA : OP_RD_HI_REG;
      end
      CMD_STATUS: begin
        push_item.op = OP_STATUS;
      end
      CMD_TICK: begin
        push_item.op = OP_TICK;
      end
      default: begin
        // select is handled here; the unused code does nothing
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

  // Register select is tracked on the front side
  always_ff @(posedge clk) begin
    if (rst) begin
      register_select <= '0;
    end else if (accept && cmd == CMD_SELECT) begin
      register_select <= data_byte[REG_AW-1:0];
    end
  end

endmodule

`default_nettype wire

[design/vdc_queue.sv]
`default_nettype none

module vdc_queue
  import vdc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  head,
  output qstat_t qstat
);

  item_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

[design/vdc_exec.sv]
`default_nettype none

module vdc_exec
  import vdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      head,
  input  qstat_t     qstat,
  output logic       pop,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_CP_RD = 4'b0100,
    ST_CP_WR = 4'b1000
  } state_t;

  state_t state;

  logic [15:0] regs [REG_COUNT];
  logic [15:0] vram [VRAM_WORDS];

  logic [15:0]        vram_rdata;
  logic [15:0]        vram_raddr;
  logic [15:0]        vram_waddr;
  logic [15:0]        vram_wdata;
  logic               vram_we;

  logic [7:0]  write_low_latch;
  logic [6:0]  status_bits;
  logic [20:0] copy_countdown;
  logic [3:0]  dma_clocks_per_word;

  logic [15:0] copy_src;
  logic [15:0] copy_dst;
  logic [15:0] copy_left;
  logic        pf_step;

  logic [15:0] step_size;
  logic [15:0] src_step;
  logic [15:0] dst_step;
  logic        out_free;
  logic        is_read;
  logic [7:0]  rd_byte;
  logic [16:0] copy_len;
  logic [3:0]  cpw_eff;
  logic [20:0] copy_clocks;

  assign cfg_ready = 1'b1;

  // Address step and copy direction
  always_comb begin
    case (regs[REG_CR][12:11])
      2'd0:    step_size = 16'd1;
      2'd1:    step_size = 16'd32;
      2'd2:    step_size = 16'd64;
      default: step_size = 16'd128;
    endcase
    src_step = regs[REG_DCR][2] ? 16'hffff : 16'd1;
    dst_step = regs[REG_DCR][3] ? 16'hffff : 16'd1;
  end

  // Issue: take the head item when idle and, for a read, when the result slot can take it
  assign out_free = !rsp_valid || !rsp_stall;
  assign is_read  = (head.op == OP_RD_LO) || (head.op == OP_RD_HI_DATA) ||
                    (head.op == OP_RD_HI_REG) || (head.op == OP_STATUS);
  assign pop      = (state == ST_IDLE) && !qstat.empty && (!is_read || out_free);

  // Byte returned by a read
  always_comb begin
    case (head.op)
      OP_RD_LO:      rd_byte = regs[head.sel][7:0];
      OP_RD_HI_DATA: rd_byte = regs[REG_VRR][15:8];
      OP_RD_HI_REG:  rd_byte = regs[head.sel][15:8];
      OP_STATUS:     rd_byte = {1'b0, status_bits};
      default:       rd_byte = 8'h00;
    endcase
  end

  // Copy length and busy time
  assign copy_len    = {1'b0, head.data, regs[REG_LENR][7:0]} + 17'd1;
  assign cpw_eff     = (dma_clocks_per_word == 4'd0) ? 4'd1 : dma_clocks_per_word;
  assign copy_clocks = 21'(copy_len) * 21'(cpw_eff);

  // Video memory port selection
  always_comb begin
    vram_raddr = regs[REG_MARR];
    vram_waddr = regs[REG_MAWR];
    vram_wdata = {head.data, write_low_latch};
    vram_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head.op == OP_REG_LO) begin
          vram_raddr = {regs[REG_MARR][15:8], head.data};
        end else if (head.op == OP_REG_HI) begin
          vram_raddr = {head.data, regs[REG_MARR][7:0]};
        end
        vram_we = pop && (head.op == OP_VRAM_WR);
      end
      ST_CP_RD: begin
        vram_raddr = copy_src;
      end
      ST_CP_WR: begin
        vram_waddr = copy_dst;
        vram_wdata = vram_rdata;
        vram_we    = 1'b1;
      end
      default: begin
        vram_we = 1'b0;
      end
    endcase
  end

  // Video memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (vram_we) begin
      vram[vram_waddr[VRAM_AW-1:0]] <= vram_wdata;
    end
    vram_rdata <= vram[vram_raddr[VRAM_AW-1:0]];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dma_clocks_per_word <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      dma_clocks_per_word <= cfg_data;
    end
  end

  // Response register: set by an issued read, cleared once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop && is_read) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Control, register file and status
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[REG_AW'(i)] <= reg_reset_value(REG_AW'(i));
      end
      state           <= ST_IDLE;
      write_low_latch <= '0;
      status_bits     <= '0;
      copy_countdown  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (head.op)
              OP_LATCH_LO: begin
                write_low_latch <= head.data;
              end
              OP_REG_LO: begin
                regs[head.sel][7:0] <= head.data;
                if (head.sel == REG_MARR) begin
                  state <= ST_FETCH;
                end
              end
              OP_VRAM_WR: begin
                regs[REG_MAWR] <= regs[REG_MAWR] + step_size;
              end
              OP_REG_HI: begin
                regs[head.sel][15:8] <= head.data;
                if (head.sel == REG_MARR) begin
                  state <= ST_FETCH;
                end else if (head.sel == REG_LENR) begin
                  copy_countdown         <= copy_clocks;
                  status_bits[STAT_BUSY] <= 1'b1;
                  state                  <= ST_CP_RD;
                end
              end
              OP_RD_HI_DATA: begin
                state <= ST_FETCH;
              end
              OP_STATUS: begin
                status_bits <= status_bits & STAT_KEEP_MASK;
              end
              OP_TICK: begin
                if (copy_countdown != '0) begin
                  if (copy_countdown > 21'(head.elapsed)) begin
                    copy_countdown <= copy_countdown - 21'(head.elapsed);
                  end else begin
                    copy_countdown         <= '0;
                    status_bits[STAT_BUSY] <= 1'b0;
                    status_bits[STAT_DONE] <= status_bits[STAT_DONE] | regs[REG_DCR][1];
                  end
                end
              end
              default: begin
                // plain reads change no state here
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_FETCH: begin
          // prefetched word lands in the data port
          regs[REG_VRR] <= vram_rdata;
          if (pf_step) begin
            regs[REG_VRRH] <= vram_rdata;
            regs[REG_MARR] <= regs[REG_MARR] + step_size;
          end
          state <= ST_IDLE;
        end
        ST_CP_RD: begin
          state <= ST_CP_WR;
        end
        ST_CP_WR: begin
          if (copy_left == '0) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_CP_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result byte and copy walk
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop) begin
      if (is_read) begin
        read_data <= rd_byte;
      end
      pf_step   <= (head.op != OP_REG_LO);
      copy_src  <= regs[REG_SOUR];
      copy_dst  <= regs[REG_DESR];
      copy_left <= {head.data, regs[REG_LENR][7:0]};
    end else if (state == ST_CP_WR) begin
      copy_src  <= copy_src + src_step;
      copy_dst  <= copy_dst + dst_step;
      copy_left <= copy_left - 16'd1;
    end
  end

endmodule

`default_nettype wire

[design/video_register_port_with_vram_dma.sv]
// Register port of a tile video controller with a VRAM-to-VRAM copy engine.
// Request channel (req_valid / req_stall): one bus byte access per transfer:
// cmd, data_byte and elapsed_clocks. Response channel (rsp_valid / rsp_stall):
// one read_data byte per read low, read high or status access, in order.
// Configuration channel (cfg_valid / cfg_ready): cfg_data sets the clocks
// charged per copied word; cfg_ready is always high.
// A read accepted into an idle block is registered in the queue and then in
// the response register, which presents its byte. Most accesses are done in
// the idle state of the execute side; accesses that prefetch from video
// memory also pass through a fetch state for the registered memory read. A
// copy holds the execute side for one read state and one write state per
// word through the single memory port pair.
// A four-entry queue separates decode from execution, so requests keep being
// accepted while a copy runs or a response waits; req_stall rises only when
// that queue is full. A stalled response holds its byte, and the execute side
// stops before the next read until the response register is free.
// Reset (rst, synchronous) restores the register file defaults, clears
// status, countdown, select and latch, and empties the queue. Video memory
// is not cleared and is undefined until written.

`default_nettype none

module video_register_port_with_vram_dma
  import vdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] data_byte,
  input  logic [7:0] elapsed_clocks,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  logic   push;
  item_t  push_item;
  logic   pop;
  item_t  head;
  qstat_t qstat;

  vdc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .elapsed_clocks (elapsed_clocks),
    .qstat          (qstat),
    .push           (push),
    .push_item      (push_item)
  );

  vdc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  vdc_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .read_data (read_data)
  );

endmodule

`default_nettype wire

[design/vdc_checker.sv]
`default_nettype none

module vdc_checker
  import vdc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic [2:0] cmd,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic [7:0] read_data
);

  logic       rd_in;
  logic       rd_out;
  logic [3:0] pending;

  assign rd_in  = req_valid && !req_stall &&
                  (cmd == CMD_RD_LO || cmd == CMD_RD_HI || cmd == CMD_STATUS);
  assign rd_out = rsp_valid && !rsp_stall;

  // Reads accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(rd_in) - 4'(rd_out);
    end
  end

  // No response without an outstanding read
  a_rsp_has_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 4'd0)
    else $error("response without outstanding read");

  // Queue plus response register bound the outstanding reads
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'(QUEUE_DEPTH + 1))
    else $error("too many outstanding reads");

  // Reset leaves no response and an open request channel
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("channels not clean after reset");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data))
    else $error("stalled response changed");

endmodule

bind video_register_port_with_vram_dma vdc_checker u_vdc_checker (.*);

`default_nettype wire

[tb/video_register_port_with_vram_dma_tb.sv]
`timescale 1ns / 1ps

module video_register_port_with_vram_dma_tb;
  import vdc_pkg::*;

  localparam logic [2:0]  CMD_UNUSED       = 3'd7;
  // copy control bits (register 15)
  localparam logic [15:0] DCR_DONE_EN_BIT  = 16'h0002;
  localparam logic [15:0] DCR_SRC_DOWN_BIT = 16'h0004;
  localparam logic [15:0] DCR_DST_DOWN_BIT = 16'h0008;
  localparam logic [15:0] SHORT_COPY_MASK  = 16'h001f;
  localparam int SEED_WORDS    = 16;
  localparam int PHASE_ITEMS   = 320;
  localparam int STALL_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int MAX_SHOWN     = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [2:0] cmd = CMD_SELECT;
  logic [7:0] data_byte = 8'h00;
  logic [7:0] elapsed_clocks = 8'h00;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [7:0] read_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = 4'd0;

  // predicted block state
  logic [15:0]       reg_model [REG_COUNT];
  logic [15:0]       vram_model [VRAM_WORDS];
  logic [REG_AW-1:0] sel_model;
  logic [7:0]        latch_model;
  logic [6:0]        status_model;
  logic [20:0]       countdown_model;
  logic [3:0]        clocks_per_word;
  logic [7:0]        read_bytes_due [$];

  int mismatches    = 0;
  int accesses_sent = 0;
  int quiet_cycles  = 0;
  int rsp_hold_left = 0;
  bit idle_enabled  = 1'b1;

  video_register_port_with_vram_dma u_dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .elapsed_clocks (elapsed_clocks),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .read_data      (read_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void reset_model();
    int i;
    for (i = 0; i < REG_COUNT; i++) reg_model[REG_AW'(i)] = 16'h0000;
    reg_model[REG_MWR] = 16'h0010;
    reg_model[REG_HSR] = 16'h0202;
    reg_model[REG_HDR] = 16'h031f;
    reg_model[REG_VPR] = 16'h0f02;
    reg_model[REG_VDW] = 16'h00ef;
    reg_model[REG_VCR] = 16'h0003;
    sel_model       = '0;
    latch_model     = 8'h00;
    status_model    = 7'h00;
    countdown_model = 21'd0;
    clocks_per_word = 4'd4;
  endfunction

  function automatic logic [15:0] vram_peek(input logic [15:0] addr);
    return vram_model[addr[VRAM_AW-1:0]];
  endfunction

  // address increment chosen by control register bits 12:11
  function automatic logic [15:0] address_step();
    case (reg_model[REG_CR][12:11])
      2'd0:    return 16'd1;
      2'd1:    return 16'd32;
      2'd2:    return 16'd64;
      default: return 16'd128;
    endcase
  endfunction

  function automatic void prefetch_read_word();
    reg_model[REG_VRR]  = vram_peek(reg_model[REG_MARR]);
    reg_model[REG_VRRH] = reg_model[REG_VRR];
    reg_model[REG_MARR] = reg_model[REG_MARR] + address_step();
  endfunction

  function automatic void run_block_copy();
    logic [15:0] src;
    logic [15:0] dst;
    int words;
    int charge;
    int i;
    src    = reg_model[REG_SOUR];
    dst    = reg_model[REG_DESR];
    words  = int'(reg_model[REG_LENR]) + 1;
    charge = (clocks_per_word == 4'd0) ? 1 : int'(clocks_per_word);
    countdown_model = 21'(words * charge);
    status_model[STAT_BUSY] = 1'b1;
    // word by word, so an overlapping copy sees its own writes
    for (i = 0; i < words; i++) begin
      vram_model[dst[VRAM_AW-1:0]] = vram_peek(src);
      src = ((reg_model[REG_DCR] & DCR_SRC_DOWN_BIT) != 0) ? src - 16'd1 : src + 16'd1;
      dst = ((reg_model[REG_DCR] & DCR_DST_DOWN_BIT) != 0) ? dst - 16'd1 : dst + 16'd1;
    end
  endfunction

  function automatic void predict_access(input logic [2:0] c, input logic [7:0] d,
                                         input logic [7:0] e);
    case (c)
      CMD_SELECT: sel_model = d[REG_AW-1:0];
      CMD_WR_LO: begin
        if (sel_model == REG_VRR) latch_model = d;
        else reg_model[sel_model][7:0] = d;
        if (sel_model == REG_MARR) reg_model[REG_VRR] = vram_peek(reg_model[REG_MARR]);
      end
      CMD_WR_HI: begin
        if (sel_model == REG_VRR) begin
          vram_model[reg_model[REG_MAWR][VRAM_AW-1:0]] = {d, latch_model};
          reg_model[REG_MAWR] = reg_model[REG_MAWR] + address_step();
        end else begin
          reg_model[sel_model][15:8] = d;
          if (sel_model == REG_MARR) prefetch_read_word();
          else if (sel_model == REG_LENR) run_block_copy();
        end
      end
      CMD_RD_LO: read_bytes_due.push_back(reg_model[sel_model][7:0]);
      CMD_RD_HI: begin
        if (sel_model == REG_VRR || sel_model == REG_VRRH) begin
          read_bytes_due.push_back(reg_model[REG_VRR][15:8]);
          prefetch_read_word();
        end else begin
          read_bytes_due.push_back(reg_model[sel_model][15:8]);
        end
      end
      CMD_STATUS: begin
        read_bytes_due.push_back({1'b0, status_model});
        status_model = status_model & STAT_KEEP_MASK;
      end
      CMD_TICK: begin
        if (countdown_model != 0) begin
          if (countdown_model > 21'(e)) begin
            countdown_model = countdown_model - 21'(e);
          end else begin
            countdown_model = 21'd0;
            status_model[STAT_BUSY] = 1'b0;
            if ((reg_model[REG_DCR] & DCR_DONE_EN_BIT) != 0) status_model[STAT_DONE] = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- bus side

  // one access transfer; the model is updated at the accepting edge
  task automatic drive_access(input logic [2:0] c, input logic [7:0] d, input logic [7:0] e);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid      <= 1'b1;
    cmd            <= c;
    data_byte      <= d;
    elapsed_clocks <= e;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_access(c, d, e);
    accesses_sent++;
  endtask

  task automatic access(input logic [2:0] c, input logic [7:0] d);
    drive_access(c, d, 8'($urandom));
  endtask

  task automatic write_reg(input logic [REG_AW-1:0] r, input logic [15:0] v);
    access(CMD_SELECT, {3'($urandom), r});
    access(CMD_WR_LO, v[7:0]);
    access(CMD_WR_HI, v[15:8]);
  endtask

  task automatic read_reg(input logic [REG_AW-1:0] r);
    access(CMD_SELECT, {3'($urandom), r});
    access(CMD_RD_LO, 8'($urandom));
    access(CMD_RD_HI, 8'($urandom));
  endtask

  task automatic tick_until_idle();
    while (countdown_model != 0) drive_access(CMD_TICK, 8'($urandom), 8'hff);
  endtask

  // Flush with a harmless read: once its byte is back, all earlier work is done.
  task automatic settle_block();
    access(CMD_RD_LO, 8'($urandom));
    req_valid <= 1'b0;
    while (read_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_clocks_per_word(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    clocks_per_word = v;
  endtask

  // ---------------------------------------------------------------- response side

  // random stall bursts
  always @(posedge clk) begin
    if (rsp_hold_left != 0) begin
      rsp_stall     <= 1'b1;
      rsp_hold_left <= rsp_hold_left - 1;
    end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
      rsp_stall     <= 1'b1;
      rsp_hold_left <= $urandom_range(0, 3);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_read_bytes
    logic [7:0] want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (read_bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected read_data transfer %02h at %0t", read_data, $time);
      end else begin
        want = read_bytes_due.pop_front();
        if (read_data !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("read_data mismatch: expected %02h, got %02h at %0t",
                     want, read_data, $time);
        end
      end
    end
  end

  // watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("video_register_port_with_vram_dma test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    int r;
    for (r = int'(REG_MWR); r <= int'(REG_VCR); r++) read_reg(REG_AW'(r));
    read_reg(REG_MAWR);
    access(CMD_STATUS, 8'h00);
  endtask

  // Seed a few words, then let an overlapping copy spread them over all of
  // video memory, so no later read can hit an unwritten word.
  task automatic test_fill_video_memory();
    int i;
    write_reg(REG_MAWR, 16'h0000);
    access(CMD_SELECT, {3'b000, REG_VRR});
    for (i = 0; i < SEED_WORDS; i++) begin
      if (i == 0) begin
        access(CMD_WR_LO, 8'h00);
        access(CMD_WR_HI, 8'h00);
      end else if (i == 1) begin
        access(CMD_WR_LO, 8'hff);
        access(CMD_WR_HI, 8'hff);
      end else begin
        access(CMD_WR_LO, 8'($urandom));
        access(CMD_WR_HI, 8'($urandom));
      end
    end
    write_reg(REG_DCR, 16'h0000);
    write_reg(REG_SOUR, 16'h0000);
    write_reg(REG_DESR, 16'(SEED_WORDS));
    write_reg(REG_LENR, 16'(VRAM_WORDS - SEED_WORDS - 1));
    settle_block();
  endtask

  task automatic test_data_port();
    int s;
    write_reg(REG_MAWR, 16'hffa0);
    // each address step; the write address wraps past the top
    for (s = 0; s < 4; s++) begin
      write_reg(REG_CR, {3'($urandom), 2'(s), 11'($urandom)});
      access(CMD_SELECT, {3'b111, REG_VRR});
      access(CMD_WR_LO, (s % 2 == 0) ? 8'hff : 8'h00);
      access(CMD_WR_HI, (s % 2 == 0) ? 8'h00 : 8'hff);
      read_reg(REG_MAWR);
    end
    // low byte of read address only refetches, no step
    access(CMD_SELECT, {3'b000, REG_MARR});
    access(CMD_WR_LO, 8'hff);
    read_reg(REG_VRRH);
    read_reg(REG_VRR);
    // full read address write prefetches and steps across the wrap
    write_reg(REG_MARR, 16'hfffe);
    read_reg(REG_MARR);
    read_reg(REG_VRR);
    write_reg(REG_VRRH, 16'($urandom));
    read_reg(REG_VRRH);
  endtask

  task automatic test_copy_cases();
    // both addresses count down, the source through zero, completion flag enabled
    write_reg(REG_DCR, DCR_DONE_EN_BIT | DCR_SRC_DOWN_BIT | DCR_DST_DOWN_BIT);
    write_reg(REG_SOUR, 16'h0002);
    write_reg(REG_DESR, 16'h8001);
    write_reg(REG_LENR, 16'h0004);
    access(CMD_STATUS, 8'h00);
    drive_access(CMD_TICK, 8'hff, 8'h00);
    drive_access(CMD_TICK, 8'h00, 8'h01);
    // new copy while busy reloads the countdown; source wraps upward
    write_reg(REG_DCR, DCR_DONE_EN_BIT);
    write_reg(REG_SOUR, 16'hfffd);
    write_reg(REG_DESR, 16'h4000);
    access(CMD_SELECT, {3'b000, REG_LENR});
    access(CMD_WR_HI, 8'h00);
    access(CMD_STATUS, 8'h00);
    tick_until_idle();
    access(CMD_STATUS, 8'h00);
    access(CMD_STATUS, 8'h00);
    // completion flag disabled
    write_reg(REG_DCR, 16'h0000);
    access(CMD_SELECT, {3'b000, REG_LENR});
    access(CMD_WR_HI, 8'h00);
    tick_until_idle();
    access(CMD_STATUS, 8'h00);
    // read back what the first copy wrote
    write_reg(REG_MARR, 16'h7ffd);
    access(CMD_SELECT, {3'b000, REG_VRR});
    repeat (5) begin
      access(CMD_RD_LO, 8'h00);
      access(CMD_RD_HI, 8'h00);
    end
  endtask

  task automatic test_unused_command();
    access(CMD_SELECT, {3'b000, REG_LENR});
    access(CMD_UNUSED, 8'hff);
    access(CMD_UNUSED, 8'h00);
    access(CMD_RD_LO, 8'h00);
    access(CMD_RD_HI, 8'h00);
    access(CMD_STATUS, 8'h00);
  endtask

  task automatic test_longest_copy();
    settle_block();
    load_clocks_per_word(4'd1);
    write_reg(REG_DCR, DCR_DONE_EN_BIT |
              (16'($urandom) & (DCR_SRC_DOWN_BIT | DCR_DST_DOWN_BIT)));
    write_reg(REG_SOUR, 16'($urandom));
    write_reg(REG_DESR, 16'($urandom));
    write_reg(REG_LENR, 16'hffff);
    access(CMD_STATUS, 8'h00);
    tick_until_idle();
    access(CMD_STATUS, 8'h00);
    read_reg(REG_LENR);
  endtask

  // mostly well-formed access sequences with random content, some noise
  task automatic random_traffic(input int n);
    int goal;
    int kind;
    int k;
    int i;
    logic [REG_AW-1:0] r;
    logic [15:0] v;
    logic [2:0] c;
    logic [7:0] d;
    goal = accesses_sent + n;
    while (accesses_sent < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 14) begin
        r = REG_AW'($urandom);
        v = 16'($urandom);
        if (r == REG_LENR) v = v & SHORT_COPY_MASK;
        write_reg(r, v);
      end else if (kind < 28) begin
        read_reg(REG_AW'($urandom));
      end else if (kind < 46) begin
        // burst of video memory writes
        if ($urandom_range(0, 2) == 0) write_reg(REG_CR, 16'($urandom));
        write_reg(REG_MAWR, 16'($urandom));
        access(CMD_SELECT, {3'($urandom), REG_VRR});
        k = $urandom_range(1, 8);
        for (i = 0; i < k; i++) begin
          access(CMD_WR_LO, 8'($urandom));
          access(CMD_WR_HI, 8'($urandom));
        end
      end else if (kind < 60) begin
        // burst of reads through the data port
        if ($urandom_range(0, 3) == 0) begin
          access(CMD_SELECT, {3'($urandom), REG_MARR});
          access(CMD_WR_LO, 8'($urandom));
        end else begin
          write_reg(REG_MARR, 16'($urandom));
        end
        access(CMD_SELECT, {3'($urandom), ($urandom_range(0, 1) ? REG_VRR : REG_VRRH)});
        k = $urandom_range(1, 8);
        for (i = 0; i < k; i++) begin
          access(CMD_RD_LO, 8'($urandom));
          access(CMD_RD_HI, 8'($urandom));
        end
      end else if (kind < 74) begin
        // short block copy
        write_reg(REG_DCR, 16'($urandom));
        write_reg(REG_SOUR, 16'($urandom));
        write_reg(REG_DESR, 16'($urandom));
        write_reg(REG_LENR, 16'($urandom_range(0, 31)));
      end else if (kind < 90) begin
        k = $urandom_range(0, 4);
        for (i = 0; i < k; i++) drive_access(CMD_TICK, 8'($urandom), 8'($urandom));
        access(CMD_STATUS, 8'($urandom));
      end else begin
        // noise; keep stray copy lengths short
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) begin
          c = 3'($urandom);
          d = 8'($urandom);
          if (c == CMD_WR_HI && sel_model == REG_LENR) d = d & 8'h01;
          drive_access(c, d, 8'($urandom));
        end
      end
    end
  endtask

  // one random phase per clocks-per-word setting; the last runs without idling
  task automatic test_random_phases();
    int p;
    logic [3:0] v;
    for (p = 0; p < 5; p++) begin
      case (p)
        0:       v = 4'd1;
        1:       v = 4'd11;
        2:       v = 4'd0;   // treated as a setting of one
        default: v = 4'($urandom_range(1, 11));
      endcase
      settle_block();
      load_clocks_per_word(v);
      if (p == 4) idle_enabled = 1'b0;
      random_traffic(PHASE_ITEMS);
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_fill_video_memory();
    test_data_port();
    test_copy_cases();
    test_unused_command();
    test_longest_copy();
    test_random_phases();

    req_valid <= 1'b0;
    while (read_bytes_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("video_register_port_with_vram_dma test passed");
    end else begin
      $display("video_register_port_with_vram_dma test failed");
    end
    $finish;
  end

endmodule
